/* rtl/deadline_timer_queue_assert.svh */
// Assertion macros used by the timer queue datapath.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dtq_pkg.sv */
// Shared types and constants of the deadline timer queue.
// Used by dtq_ctrl, dtq_datapath and deadline_timer_queue; depends on nothing.
package dtq_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ID_W = 4;
  localparam int TIME_W = 64;
  localparam int DELAY_W = 32;
  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 40;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_IGNORED = 2'd3
  } req_type_e;

  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_DELAY = 1'b1;

  typedef struct packed {
    logic load;
    logic ptr_clr;
    logic ptr_inc;
    logic insert;
    logic remove;
    logic pop_fire;
    logic ld_diff;
    logic emit_delay;
  } dtq_cmd_t;

  typedef struct packed {
    req_type_e req;
    logic      ins_ok;
    logic      rem_ok;
    logic      ptr_end;
    logic      le_when;
    logic      le_now;
    logic      hit;
    logic      empty;
    logic      out_free;
  } dtq_sts_t;

endpackage

/* rtl/deadline_timer_queue.sv */
// Channel   Dir  Contents
// s_axis    in   tuser = req_type; tdata = timer_id, deadline, now
// m_axis    out  tuser = result_kind; tlast = last_result; tdata = fired_timer, next_delay
// config    in   wake_limit_we_i, wake_limit_i
// An item is loaded and decoded; an enqueue then walks past each queued timer at or before
// the new deadline and places it, then emits one fired word per expired timer and the delay
// word; a dequeue walks the entries ahead of the timer and removes it.
// A tick emits the fired words and the delay word; a stalled output holds those words.
// Reset clears the queue and sets the wake limit to 0x7FFFFFFF; no clearing pass is needed.
// Top level of the timer queue; depends on dtq_pkg, dtq_ctrl and dtq_datapath.
module deadline_timer_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dtq_pkg::S_DATA_W-1:0] s_axis_tdata,  // timer_id, deadline, now
  input  logic [1:0]                   s_axis_tuser,  // req_type
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [dtq_pkg::M_DATA_W-1:0] m_axis_tdata,  // fired_timer, next_delay, zero pad
  output logic                         m_axis_tuser,  // result_kind
  output logic                         m_axis_tlast,
  input  logic                         wake_limit_we_i,
  input  logic [dtq_pkg::DELAY_W-1:0]  wake_limit_i
);

  dtq_pkg::dtq_cmd_t           cmd;
  dtq_pkg::dtq_sts_t           sts;
  logic [dtq_pkg::ID_W-1:0]    fired;
  logic [dtq_pkg::DELAY_W-1:0] delay;

  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dtq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_req_i    (s_axis_tuser),
    .wl_we_i     (wake_limit_we_i),
    .wl_data_i   (wake_limit_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_fired_o (fired),
    .out_delay_o (delay),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, delay, fired};

endmodule

/* rtl/dtq_datapath.sv */
// Datapath of the timer queue: deadline store, sorted id list, walk pointer,
// wake limit register and output register. Depends on dtq_pkg and the assert header.
`include "deadline_timer_queue_assert.svh"

module dtq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dtq_pkg::S_DATA_W-1:0]  in_data_i,
  input  logic [1:0]                    in_req_i,
  input  logic                          wl_we_i,
  input  logic [dtq_pkg::DELAY_W-1:0]   wl_data_i,
  input  dtq_pkg::dtq_cmd_t             cmd_i,
  output dtq_pkg::dtq_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [dtq_pkg::ID_W-1:0]      out_fired_o,
  output logic [dtq_pkg::DELAY_W-1:0]   out_delay_o,
  output logic                          out_last_o
);

  logic [dtq_pkg::TIME_W-1:0]  dl_q [dtq_pkg::SLOTS];
  logic [dtq_pkg::IDX_W-1:0]   order_q [dtq_pkg::SLOTS];
  logic [dtq_pkg::SLOTS-1:0]   queued_q;
  logic [dtq_pkg::CNT_W-1:0]   cnt_q;
  logic [dtq_pkg::CNT_W-1:0]   ptr_q;
  logic [dtq_pkg::DELAY_W-1:0] wl_q;
  logic [1:0]                  req_q;
  logic [dtq_pkg::ID_W-1:0]    id_q;
  logic [dtq_pkg::TIME_W-1:0]  when_q;
  logic [dtq_pkg::TIME_W-1:0]  now_q;
  logic [dtq_pkg::TIME_W-1:0]  diff_q;
  logic                        out_valid_q;
  logic                        out_kind_q;
  logic [dtq_pkg::ID_W-1:0]    out_fired_q;
  logic [dtq_pkg::DELAY_W-1:0] out_delay_q;
  logic                        out_last_q;

  logic [dtq_pkg::IDX_W-1:0]   idx;
  logic [dtq_pkg::IDX_W-1:0]   rd_id;
  logic [dtq_pkg::TIME_W-1:0]  rd_dl;
  logic                        id_ok;
  logic                        out_free;
  logic [dtq_pkg::DELAY_W-1:0] delay_val;

  assign idx      = dtq_pkg::IDX_W'(id_q);
  assign rd_id    = order_q[ptr_q[dtq_pkg::IDX_W-1:0]];
  assign rd_dl    = dl_q[rd_id];
  assign id_ok    = dtq_pkg::CNT_W'(id_q) < dtq_pkg::CNT_W'(dtq_pkg::SLOTS);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (cnt_q == '0) begin
      delay_val = wl_q;
    end else if (diff_q[dtq_pkg::TIME_W-1:dtq_pkg::DELAY_W] == '0 &&
                 diff_q[dtq_pkg::DELAY_W-1:0] < wl_q) begin
      delay_val = diff_q[dtq_pkg::DELAY_W-1:0];
    end else begin
      delay_val = wl_q;
    end
  end

  always_comb begin
    sts_o.req      = dtq_pkg::req_type_e'(req_q);
    sts_o.ins_ok   = id_ok && !queued_q[idx] &&
                     (cnt_q < dtq_pkg::CNT_W'(dtq_pkg::SLOTS));
    sts_o.rem_ok   = id_ok && queued_q[idx];
    sts_o.ptr_end  = ptr_q == cnt_q;
    sts_o.le_when  = rd_dl <= when_q;
    sts_o.le_now   = rd_dl <= now_q;
    sts_o.hit      = rd_id == idx;
    sts_o.empty    = cnt_q == '0;
    sts_o.out_free = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= in_req_i;
      id_q   <= in_data_i[dtq_pkg::ID_W-1:0];
      when_q <= in_data_i[dtq_pkg::ID_W +: dtq_pkg::TIME_W];
      now_q  <= in_data_i[dtq_pkg::ID_W+dtq_pkg::TIME_W +: dtq_pkg::TIME_W];
    end
    if (cmd_i.ld_diff) begin
      diff_q <= rd_dl - now_q;
    end
    if (cmd_i.insert) begin
      dl_q[idx] <= when_q;
      for (int i = 1; i < dtq_pkg::SLOTS; i++) begin
        if (dtq_pkg::CNT_W'(i) > ptr_q) begin
          order_q[i] <= order_q[i-1];
        end
      end
      order_q[ptr_q[dtq_pkg::IDX_W-1:0]] <= idx;
    end else if (cmd_i.remove) begin
      for (int i = 0; i < dtq_pkg::SLOTS - 1; i++) begin
        if (dtq_pkg::CNT_W'(i) >= ptr_q) begin
          order_q[i] <= order_q[i+1];
        end
      end
    end else if (cmd_i.pop_fire) begin
      for (int i = 0; i < dtq_pkg::SLOTS - 1; i++) begin
        order_q[i] <= order_q[i+1];
      end
    end
    if (cmd_i.pop_fire) begin
      out_kind_q  <= dtq_pkg::KIND_FIRED;
      out_fired_q <= dtq_pkg::ID_W'(order_q[0]);
      out_delay_q <= '0;
      out_last_q  <= 1'b0;
    end else if (cmd_i.emit_delay) begin
      out_kind_q  <= dtq_pkg::KIND_DELAY;
      out_fired_q <= '0;
      out_delay_q <= delay_val;
      out_last_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q    <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      wl_q        <= 32'h7FFF_FFFF;
      out_valid_q <= 1'b0;
    end else begin
      if (wl_we_i) begin
        wl_q <= wl_data_i;
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.insert) begin
        queued_q[idx] <= 1'b1;
        cnt_q         <= cnt_q + 1'b1;
      end else if (cmd_i.remove) begin
        queued_q[idx] <= 1'b0;
        cnt_q         <= cnt_q - 1'b1;
      end else if (cmd_i.pop_fire) begin
        queued_q[order_q[0]] <= 1'b0;
        cnt_q                <= cnt_q - 1'b1;
      end
      if (cmd_i.pop_fire || cmd_i.emit_delay) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_fired_o = out_fired_q;
  assign out_delay_o = out_delay_q;
  assign out_last_o  = out_last_q;

  `DTQ_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= dtq_pkg::CNT_W'(dtq_pkg::SLOTS), "count overflow")
  `DTQ_ASSERT_NOW(a_count_flags, 1'b1, $countones(queued_q) == 32'(cnt_q), "flags and count disagree")
  `DTQ_ASSERT_NOW(a_pop_nonempty, cmd_i.pop_fire, cnt_q != '0 && out_free, "pop from empty queue")
  `DTQ_ASSERT_NEXT(a_emit_valid, cmd_i.pop_fire || cmd_i.emit_delay, out_valid_q, "word not presented")

endmodule

/* rtl/dtq_ctrl.sv */
// Controller state machine of the timer queue: sequences the sorted walk,
// insertion, removal, expiry and delay report. Depends on dtq_pkg.
module dtq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dtq_pkg::dtq_sts_t sts_i,
  output dtq_pkg::dtq_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_INSERT,
    ST_LOCATE,
    ST_REMOVE,
    ST_EXPIRE,
    ST_DIFF,
    ST_REPORT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.ptr_clr = 1'b1;
        unique case (sts_i.req)
          dtq_pkg::REQ_ENQUEUE: state_d = sts_i.ins_ok ? ST_FIND : ST_EXPIRE;
          dtq_pkg::REQ_DEQUEUE: state_d = sts_i.rem_ok ? ST_LOCATE : ST_IDLE;
          dtq_pkg::REQ_TICK:    state_d = ST_EXPIRE;
          default:              state_d = ST_IDLE;
        endcase
      end
      ST_FIND: begin
        if (sts_i.ptr_end || !sts_i.le_when) begin
          state_d = ST_INSERT;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      ST_INSERT: begin
        cmd_o.insert  = 1'b1;
        cmd_o.ptr_clr = 1'b1;
        state_d       = ST_EXPIRE;
      end
      ST_LOCATE: begin
        if (sts_i.hit) begin
          state_d = ST_REMOVE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      ST_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_EXPIRE: begin
        if (!sts_i.empty && sts_i.le_now) begin
          cmd_o.pop_fire = sts_i.out_free;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.ld_diff = 1'b1;
        state_d       = ST_REPORT;
      end
      ST_REPORT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_delay = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
